>>> rtl/core/stu_pkg.sv
// stu_pkg: formats, command codes, micro-op types and the micro-program of the
// similarity transform unit. Used by stu_mac, stu_div and similarity_transform_unit.
// No dependencies.
`timescale 1ns / 1ps

package stu_pkg;

    localparam int QUAT_FRAC_BITS   = 14;
    localparam int LINEAR_FRAC_BITS = 16;

    localparam int QUAT_W = 16;
    localparam int LIN_W  = 32;

    // rounded cross-product term t, and multiplier / accumulator widths
    localparam int TV_W    = LIN_W + QUAT_W + 2 - QUAT_FRAC_BITS;
    localparam int MUL_A_W = (TV_W > LIN_W) ? TV_W : LIN_W;
    localparam int PROD_W  = MUL_A_W + LIN_W;
    localparam int ACC_W   = PROD_W + 2;

    // reciprocal divider
    localparam int DIV_W = 2 * LINEAR_FRAC_BITS + 2;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = (QUAT_FRAC_BITS >= QUAT_W - 1) ?
        {1'b0, {(QUAT_W-1){1'b1}}} : QUAT_W'(1 << QUAT_FRAC_BITS);
    localparam logic signed [LIN_W-1:0] LIN_ONE = LIN_W'(1 << LINEAR_FRAC_BITS);

    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'((1 << (QUAT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] Q_MIN = -Q_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] L_MAX = ACC_W'(64'sh7fffffff);
    localparam logic signed [ACC_W-1:0] L_MIN = -L_MAX - ACC_W'(1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPOSE = 2'd1,
        CMD_INVERT  = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        A_BQ = 3'd0,
        A_BT = 3'd1,
        A_BS = 3'd2,
        A_AT = 3'd3,
        A_SV = 3'd4,
        A_TV = 3'd5
    } a_kind_t;

    typedef enum logic [1:0] {
        B_AQ = 2'd0,
        B_RQ = 2'd1,
        B_AS = 2'd2,
        B_NS = 2'd3
    } b_kind_t;

    typedef enum logic [2:0] {
        D_NONE = 3'd0,
        D_NQ   = 3'd1,
        D_SV   = 3'd2,
        D_NS   = 3'd3,
        D_TV   = 3'd4,
        D_RV   = 3'd5
    } dst_t;

    typedef struct packed {
        logic       valid;
        a_kind_t    ak;
        logic [1:0] ai;
        b_kind_t    bk;
        logic [1:0] bi;
        logic       neg;
        logic       first;
        logic       last;
        dst_t       dst;
        logic [1:0] di;
    } uop_t;

    // control that travels with a product through the mac pipeline
    typedef struct packed {
        logic       valid;
        logic       neg;
        logic       first;
        logic       last;
        dst_t       dst;
        logic [1:0] di;
    } mac_ctl_t;

    localparam logic [5:0] STEP_ROT   = 6'd20;
    localparam logic [5:0] STEP_END   = 6'd36;
    localparam logic [5:0] STEP_INV   = 6'd37;
    localparam logic [5:0] STEP_INV_E = 6'd41;

    function automatic uop_t mk(input a_kind_t ak, input int ai, input b_kind_t bk,
                                input int bi, input logic neg, input logic first,
                                input logic last, input dst_t dst, input int di);
        uop_t u;
        u.valid = 1'b1;
        u.ak    = ak;
        u.ai    = 2'(ai);
        u.bk    = bk;
        u.bi    = 2'(bi);
        u.neg   = neg;
        u.first = first;
        u.last  = last;
        u.dst   = dst;
        u.di    = 2'(di);
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [5:0] idx);
        uop_t u;
        u = '0;
        case (idx)
            // scaled input translation and product of scales
            6'd0:  u = mk(A_BT, 0, B_AS, 0, 1'b0, 1'b1, 1'b1, D_SV, 0);
            6'd1:  u = mk(A_BT, 1, B_AS, 0, 1'b0, 1'b1, 1'b1, D_SV, 1);
            6'd2:  u = mk(A_BT, 2, B_AS, 0, 1'b0, 1'b1, 1'b1, D_SV, 2);
            6'd3:  u = mk(A_BS, 0, B_AS, 0, 1'b0, 1'b1, 1'b1, D_NS, 0);
            // hamilton product
            6'd4:  u = mk(A_BQ, 0, B_AQ, 0, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd5:  u = mk(A_BQ, 1, B_AQ, 1, 1'b1, 1'b0, 1'b0, D_NONE, 0);
            6'd6:  u = mk(A_BQ, 2, B_AQ, 2, 1'b1, 1'b0, 1'b0, D_NONE, 0);
            6'd7:  u = mk(A_BQ, 3, B_AQ, 3, 1'b1, 1'b0, 1'b1, D_NQ, 0);
            6'd8:  u = mk(A_BQ, 1, B_AQ, 0, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd9:  u = mk(A_BQ, 0, B_AQ, 1, 1'b0, 1'b0, 1'b0, D_NONE, 0);
            6'd10: u = mk(A_BQ, 3, B_AQ, 2, 1'b0, 1'b0, 1'b0, D_NONE, 0);
            6'd11: u = mk(A_BQ, 2, B_AQ, 3, 1'b1, 1'b0, 1'b1, D_NQ, 1);
            6'd12: u = mk(A_BQ, 2, B_AQ, 0, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd13: u = mk(A_BQ, 3, B_AQ, 1, 1'b1, 1'b0, 1'b0, D_NONE, 0);
            6'd14: u = mk(A_BQ, 0, B_AQ, 2, 1'b0, 1'b0, 1'b0, D_NONE, 0);
            6'd15: u = mk(A_BQ, 1, B_AQ, 3, 1'b0, 1'b0, 1'b1, D_NQ, 2);
            6'd16: u = mk(A_BQ, 3, B_AQ, 0, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd17: u = mk(A_BQ, 2, B_AQ, 1, 1'b0, 1'b0, 1'b0, D_NONE, 0);
            6'd18: u = mk(A_BQ, 1, B_AQ, 2, 1'b1, 1'b0, 1'b0, D_NONE, 0);
            6'd19: u = mk(A_BQ, 0, B_AQ, 3, 1'b0, 1'b0, 1'b1, D_NQ, 3);
            // t = 2 * (qv x v)
            6'd20: u = mk(A_SV, 2, B_RQ, 2, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd21: u = mk(A_SV, 1, B_RQ, 3, 1'b1, 1'b0, 1'b1, D_TV, 0);
            6'd22: u = mk(A_SV, 0, B_RQ, 3, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd23: u = mk(A_SV, 2, B_RQ, 1, 1'b1, 1'b0, 1'b1, D_TV, 1);
            6'd24: u = mk(A_SV, 1, B_RQ, 1, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd25: u = mk(A_SV, 0, B_RQ, 2, 1'b1, 1'b0, 1'b1, D_TV, 2);
            // steps 26 and 27 wait for the last t term
            // r = v + w * t + qv x t
            6'd28: u = mk(A_TV, 0, B_RQ, 0, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd29: u = mk(A_TV, 2, B_RQ, 2, 1'b0, 1'b0, 1'b0, D_NONE, 0);
            6'd30: u = mk(A_TV, 1, B_RQ, 3, 1'b1, 1'b0, 1'b1, D_RV, 0);
            6'd31: u = mk(A_TV, 1, B_RQ, 0, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd32: u = mk(A_TV, 0, B_RQ, 3, 1'b0, 1'b0, 1'b0, D_NONE, 0);
            6'd33: u = mk(A_TV, 2, B_RQ, 1, 1'b1, 1'b0, 1'b1, D_RV, 1);
            6'd34: u = mk(A_TV, 2, B_RQ, 0, 1'b0, 1'b1, 1'b0, D_NONE, 0);
            6'd35: u = mk(A_TV, 1, B_RQ, 1, 1'b0, 1'b0, 1'b0, D_NONE, 0);
            6'd36: u = mk(A_TV, 0, B_RQ, 2, 1'b1, 1'b0, 1'b1, D_RV, 2);
            // invert: negated translation times reciprocal, then the rotation
            6'd37: u = mk(A_AT, 0, B_NS, 0, 1'b1, 1'b1, 1'b1, D_SV, 0);
            6'd38: u = mk(A_AT, 1, B_NS, 0, 1'b1, 1'b1, 1'b1, D_SV, 1);
            6'd39: u = mk(A_AT, 2, B_NS, 0, 1'b1, 1'b1, 1'b1, D_SV, 2);
            default: u = '0;
        endcase
        return u;
    endfunction

    // shift right with rounding to nearest, ties toward plus infinity
    function automatic logic signed [ACC_W-1:0] round_sh(input logic signed [ACC_W-1:0] v,
                                                         input int sh);
        logic signed [ACC_W-1:0] half;
        half = ACC_W'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    // {clamped flag, value}
    function automatic logic [QUAT_W:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic [QUAT_W:0] r;
        if (v > Q_MAX) r = {1'b1, Q_MAX[QUAT_W-1:0]};
        else if (v < Q_MIN) r = {1'b1, Q_MIN[QUAT_W-1:0]};
        else r = {1'b0, v[QUAT_W-1:0]};
        return r;
    endfunction

    function automatic logic [LIN_W:0] sat_l(input logic signed [ACC_W-1:0] v);
        logic [LIN_W:0] r;
        if (v > L_MAX) r = {1'b1, L_MAX[LIN_W-1:0]};
        else if (v < L_MIN) r = {1'b1, L_MIN[LIN_W-1:0]};
        else r = {1'b0, v[LIN_W-1:0]};
        return r;
    endfunction

endpackage

>>> rtl/core/stu_mac.sv
// stu_mac: shared multiply-accumulate pipeline, one product per cycle.
// Stage 1 registers the product, stage 2 accumulates. Depends on stu_pkg.
`timescale 1ns / 1ps

module stu_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  stu_pkg::mac_ctl_t                   issue,
    input  logic signed [stu_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [stu_pkg::LIN_W-1:0]    op_b,
    output stu_pkg::mac_ctl_t                   wb,
    output logic signed [stu_pkg::ACC_W-1:0]    acc
);
    import stu_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 ctl1_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    mac_ctl_t                 ctl2_reg;
    logic signed [ACC_W-1:0]  term;

    always_comb begin
        term     = ctl1_reg.neg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
        acc_next = ctl1_reg.first ? term : acc_reg + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg <= issue;
            ctl2_reg <= ctl1_reg;
            prod_reg <= op_a * op_b;
            if (ctl1_reg.valid) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_comb begin
        wb       = ctl2_reg;
        wb.valid = ctl2_reg.valid && ctl2_reg.last;
    end

    assign acc = acc_reg;

endmodule

>>> rtl/core/stu_div.sv
// stu_div: restoring divider for the scale reciprocal, one quotient bit per cycle.
// Computes (2^(2*LINEAR_FRAC_BITS) + den/2) / den. Depends on stu_pkg.
`timescale 1ns / 1ps

module stu_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [stu_pkg::LIN_W-1:0]       den,
    output logic                            done,
    output logic [stu_pkg::DIV_W-1:0]       quo
);
    import stu_pkg::*;

    logic [LIN_W-1:0] den_reg;
    logic [LIN_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LIN_W:0]   rem_sh;
    logic             ge;

    always_comb begin
        rem_sh   = {rem_reg, num_reg[DIV_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? LIN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[LIN_W-1:0];
        num_next = {num_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
                den_reg  <= den;
                rem_reg  <= '0;
                num_reg  <= (DIV_W'(1) << (2 * LINEAR_FRAC_BITS)) + DIV_W'(den >> 1);
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                num_reg <= num_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

>>> rtl/core/similarity_transform_unit.sv
// similarity_transform_unit: accumulator of similarity transforms (quaternion,
// translation, uniform scale). Uses stu_pkg, stu_mac and stu_div.
//
// Input stream s_*: one request per command. s_tuser carries the command
// (load, compose, invert), s_tdata the input transform. Output stream m_*:
// one result per request, the accumulator after the command in m_tdata and
// the clamp flag in m_tuser. s_tready is high only while no command is in
// work; one command is processed at a time.
// Load and the unused code need no micro-steps. Compose runs 37 micro-steps on
// the shared 36x32 multiply-accumulate unit, one product per cycle, then drains
// the pipeline. Invert first runs the bit-serial reciprocal divider, which is
// skipped when the scale is zero, and then 22 micro-steps.
// A new request is accepted while the previous result still waits on
// m_tready; its result is held back until the output register is free.
// Reset (aresetn low, synchronous) sets the accumulator to the identity,
// translation zero and scale one, and drops m_tvalid.
`timescale 1ns / 1ps

module similarity_transform_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rot_w, rot_x, rot_y, rot_z, move_x, move_y, move_z, size_factor
    input  logic [191:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_rot_w, out_rot_x, out_rot_y, out_rot_z, out_move_x, out_move_y,
    // out_move_z, out_size_factor
    output logic [191:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser
);
    import stu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                   state_reg;
    logic [5:0]               step_reg;
    logic                     drain_reg;
    cmd_t                     cmd_reg;
    logic                     flag_reg;

    logic signed [QUAT_W-1:0] bq_reg  [4];
    logic signed [LIN_W-1:0]  bt_reg  [3];
    logic signed [LIN_W-1:0]  bs_reg;
    logic signed [QUAT_W-1:0] aq_reg  [4];
    logic signed [LIN_W-1:0]  at_reg  [3];
    logic signed [LIN_W-1:0]  as_reg;
    logic signed [QUAT_W-1:0] nq_reg  [4];
    logic signed [LIN_W-1:0]  ns_reg;
    logic signed [LIN_W-1:0]  sv_reg  [3];
    logic signed [TV_W-1:0]   tv_reg  [3];
    logic signed [LIN_W-1:0]  atn_reg [3];

    logic [191:0]             m_tdata_reg;
    logic                     m_tuser_reg;
    logic                     m_tvalid_reg;

    logic                     s_fire;
    cmd_t                     s_cmd;
    uop_t                     uop;
    mac_ctl_t                 issue;
    mac_ctl_t                 wb;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [LIN_W-1:0]  op_b;
    logic signed [QUAT_W-1:0] rq    [4];
    logic signed [ACC_W-1:0]  acc;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;
    logic [LIN_W-1:0]         as_mag;

    logic signed [ACC_W-1:0]  r_quat;
    logic signed [ACC_W-1:0]  r_lin;
    logic signed [ACC_W-1:0]  r_tv;
    logic signed [ACC_W-1:0]  rv_sum;
    logic [QUAT_W:0]          nq_sat;
    logic [LIN_W:0]           lin_sat;
    logic [LIN_W:0]           rv_sat;
    logic signed [ACC_W-1:0]  rcp_signed;
    logic [LIN_W:0]           rcp_sat;
    logic [QUAT_W:0]          conj_sat [4];

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_cmd    = cmd_t'(s_tuser);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rq[i]       = (cmd_reg == CMD_INVERT) ? nq_reg[i] : aq_reg[i];
            conj_sat[i] = sat_q(-ACC_W'(aq_reg[i]));
        end
    end

    // operand selection for the shared unit
    always_comb begin
        uop         = uop_rom(step_reg);
        issue.valid = (state_reg == S_RUN) && uop.valid;
        issue.neg   = uop.neg;
        issue.first = uop.first;
        issue.last  = uop.last;
        issue.dst   = uop.dst;
        issue.di    = uop.di;
        case (uop.ak)
            A_BQ:    op_a = MUL_A_W'(bq_reg[uop.ai]);
            A_BT:    op_a = MUL_A_W'(bt_reg[uop.ai]);
            A_BS:    op_a = MUL_A_W'(bs_reg);
            A_AT:    op_a = MUL_A_W'(at_reg[uop.ai]);
            A_SV:    op_a = MUL_A_W'(sv_reg[uop.ai]);
            A_TV:    op_a = MUL_A_W'(tv_reg[uop.ai]);
            default: op_a = '0;
        endcase
        case (uop.bk)
            B_AQ:    op_b = LIN_W'(aq_reg[uop.bi]);
            B_RQ:    op_b = LIN_W'(rq[uop.bi]);
            B_AS:    op_b = as_reg;
            B_NS:    op_b = ns_reg;
            default: op_b = '0;
        endcase
    end

    stu_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .op_a    (op_a),
        .op_b    (op_b),
        .wb      (wb),
        .acc     (acc)
    );

    assign as_mag    = as_reg[LIN_W-1] ? LIN_W'(-as_reg) : LIN_W'(as_reg);
    assign div_start = s_fire && (s_cmd == CMD_INVERT) && (as_reg != '0);

    stu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (as_mag),
        .done    (div_done),
        .quo     (div_quo)
    );

    // rounding and clamping of finished sums
    always_comb begin
        r_quat  = round_sh(acc, QUAT_FRAC_BITS);
        r_lin   = round_sh(acc, LINEAR_FRAC_BITS);
        r_tv    = round_sh(acc <<< 1, QUAT_FRAC_BITS);
        nq_sat  = sat_q(r_quat);
        lin_sat = sat_l(r_lin);
        rv_sum  = r_quat + ACC_W'(sv_reg[wb.di]);
        if (cmd_reg == CMD_COMPOSE) begin
            rv_sum = rv_sum + ACC_W'(at_reg[wb.di]);
        end
        rv_sat     = sat_l(rv_sum);
        rcp_signed = as_reg[LIN_W-1] ? -ACC_W'(div_quo) : ACC_W'(div_quo);
        rcp_sat    = sat_l(rcp_signed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            drain_reg    <= 1'b0;
            cmd_reg      <= CMD_LOAD;
            flag_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            aq_reg[0]    <= QUAT_ONE;
            for (int i = 1; i < 4; i++) aq_reg[i] <= '0;
            for (int i = 0; i < 3; i++) at_reg[i] <= '0;
            as_reg       <= LIN_ONE;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        cmd_reg  <= s_cmd;
                        flag_reg <= (s_cmd == CMD_INVERT) ?
                                    (conj_sat[1][QUAT_W] | conj_sat[2][QUAT_W] |
                                     conj_sat[3][QUAT_W]) : 1'b0;
                        for (int i = 0; i < 4; i++) begin
                            bq_reg[i] <= s_tdata[16*i +: 16];
                        end
                        for (int i = 0; i < 3; i++) begin
                            bt_reg[i] <= s_tdata[64 + 32*i +: 32];
                        end
                        bs_reg <= s_tdata[160 +: 32];
                        case (s_cmd)
                            CMD_LOAD: begin
                                for (int i = 0; i < 4; i++) begin
                                    nq_reg[i] <= s_tdata[16*i +: 16];
                                end
                                for (int i = 0; i < 3; i++) begin
                                    atn_reg[i] <= s_tdata[64 + 32*i +: 32];
                                end
                                ns_reg    <= s_tdata[160 +: 32];
                                state_reg <= S_DONE;
                            end
                            CMD_COMPOSE: begin
                                step_reg  <= '0;
                                state_reg <= S_RUN;
                            end
                            CMD_INVERT: begin
                                nq_reg[0] <= aq_reg[0];
                                for (int i = 1; i < 4; i++) begin
                                    nq_reg[i] <= conj_sat[i][QUAT_W-1:0];
                                end
                                if (as_reg == '0) begin
                                    ns_reg    <= '0;
                                    step_reg  <= STEP_INV;
                                    state_reg <= S_RUN;
                                end else begin
                                    state_reg <= S_DIV;
                                end
                            end
                            default: begin
                                for (int i = 0; i < 4; i++) nq_reg[i] <= aq_reg[i];
                                for (int i = 0; i < 3; i++) atn_reg[i] <= at_reg[i];
                                ns_reg    <= as_reg;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        ns_reg    <= rcp_sat[LIN_W-1:0];
                        flag_reg  <= flag_reg | rcp_sat[LIN_W];
                        step_reg  <= STEP_INV;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (step_reg == STEP_END) begin
                        drain_reg <= 1'b0;
                        state_reg <= S_DRAIN;
                    end else if (step_reg == STEP_INV_E) begin
                        step_reg <= STEP_ROT;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                S_DRAIN: begin
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        for (int i = 0; i < 4; i++) begin
                            aq_reg[i]            <= nq_reg[i];
                            m_tdata_reg[16*i +: 16] <= nq_reg[i];
                        end
                        for (int i = 0; i < 3; i++) begin
                            at_reg[i]                  <= atn_reg[i];
                            m_tdata_reg[64 + 32*i +: 32] <= atn_reg[i];
                        end
                        as_reg                 <= ns_reg;
                        m_tdata_reg[160 +: 32] <= ns_reg;
                        m_tuser_reg            <= flag_reg;
                        m_tvalid_reg           <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // write-back from the shared unit
            if (wb.valid) begin
                case (wb.dst)
                    D_NQ: begin
                        nq_reg[wb.di] <= nq_sat[QUAT_W-1:0];
                        flag_reg      <= flag_reg | nq_sat[QUAT_W];
                    end
                    D_SV: begin
                        sv_reg[wb.di] <= lin_sat[LIN_W-1:0];
                        flag_reg      <= flag_reg | lin_sat[LIN_W];
                    end
                    D_NS: begin
                        ns_reg   <= lin_sat[LIN_W-1:0];
                        flag_reg <= flag_reg | lin_sat[LIN_W];
                    end
                    D_TV: begin
                        tv_reg[wb.di] <= r_tv[TV_W-1:0];
                    end
                    D_RV: begin
                        atn_reg[wb.di] <= rv_sat[LIN_W-1:0];
                        flag_reg       <= flag_reg | rv_sat[LIN_W];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> tb/similarity_transform_unit_test.sv
// similarity_transform_unit_test: self-checking bench for the similarity transform
// accumulator. Drives load, compose and invert requests and checks each result
// against an in-bench fixed-point predictor. Depends on stu_pkg and the unit.
`timescale 1ns / 1ps

module similarity_transform_unit_test;
    import stu_pkg::*;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [15:0]  qw, qx, qy, qz;
        logic signed [31:0]  tx, ty, tz, sc;
    } xform_req_t;

    typedef struct packed {
        logic [191:0] data;
        logic         sat;
    } xform_res_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;

    similarity_transform_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    xform_req_t pending_reqs[$];
    xform_res_t expected_accs[$];
    longint     acc_q[4];
    longint     acc_t[3];
    longint     acc_s;
    int         errors = 0;
    int         results_seen = 0;
    int         sat_seen = 0;
    int         sent = 0;
    longint     cycles = 0;
    bit         hold_sender = 1'b0;
    bit         long_stall_req = 1'b0;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clampw(longint v, int bits, inout bit f);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            f = 1'b1;
            return hi;
        end
        if (v < lo) begin
            f = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic void rotate_by(longint q[4], longint v[3], output longint r[3]);
        longint t[3];
        longint c[3];
        t[0] = round_shift(2 * (q[2] * v[2] - q[3] * v[1]), QUAT_FRAC_BITS);
        t[1] = round_shift(2 * (q[3] * v[0] - q[1] * v[2]), QUAT_FRAC_BITS);
        t[2] = round_shift(2 * (q[1] * v[1] - q[2] * v[0]), QUAT_FRAC_BITS);
        c[0] = q[2] * t[2] - q[3] * t[1];
        c[1] = q[3] * t[0] - q[1] * t[2];
        c[2] = q[1] * t[1] - q[2] * t[0];
        for (int i = 0; i < 3; i++)
            r[i] = v[i] + round_shift(q[0] * t[i] + c[i], QUAT_FRAC_BITS);
    endfunction

    function automatic longint recip_of(longint s, inout bit f);
        longint mag;
        longint quo;
        if (s == 0)
            return 0;
        mag = (s < 0) ? -s : s;
        quo = ((longint'(1) <<< (2 * LINEAR_FRAC_BITS)) + mag / 2) / mag;
        if (s < 0)
            quo = -quo;
        return clampw(quo, 32, f);
    endfunction

    task automatic apply_command(input xform_req_t r);
        longint bq[4];
        longint bt[3];
        longint nq[4];
        longint sv[3];
        longint rv[3];
        longint ns;
        bit f;
        xform_res_t e;
        f = 1'b0;
        bq = '{r.qw, r.qx, r.qy, r.qz};
        bt = '{r.tx, r.ty, r.tz};
        case (cmd_t'(r.cmd))
            CMD_LOAD: begin
                acc_q = bq;
                acc_t = bt;
                acc_s = r.sc;
            end
            CMD_COMPOSE: begin
                nq[0] = acc_q[0]*bq[0] - acc_q[1]*bq[1] - acc_q[2]*bq[2] - acc_q[3]*bq[3];
                nq[1] = acc_q[0]*bq[1] + acc_q[1]*bq[0] + acc_q[2]*bq[3] - acc_q[3]*bq[2];
                nq[2] = acc_q[0]*bq[2] - acc_q[1]*bq[3] + acc_q[2]*bq[0] + acc_q[3]*bq[1];
                nq[3] = acc_q[0]*bq[3] + acc_q[1]*bq[2] - acc_q[2]*bq[1] + acc_q[3]*bq[0];
                for (int i = 0; i < 4; i++)
                    nq[i] = clampw(round_shift(nq[i], QUAT_FRAC_BITS), 16, f);
                for (int i = 0; i < 3; i++)
                    sv[i] = clampw(round_shift(bt[i] * acc_s, LINEAR_FRAC_BITS), 32, f);
                rotate_by(acc_q, sv, rv);
                ns = clampw(round_shift(acc_s * longint'(r.sc), LINEAR_FRAC_BITS), 32, f);
                for (int i = 0; i < 3; i++)
                    acc_t[i] = clampw(rv[i] + acc_t[i], 32, f);
                acc_q = nq;
                acc_s = ns;
            end
            CMD_INVERT: begin
                nq[0] = acc_q[0];
                for (int i = 1; i < 4; i++)
                    nq[i] = clampw(-acc_q[i], 16, f);
                ns = recip_of(acc_s, f);
                for (int i = 0; i < 3; i++)
                    sv[i] = clampw(round_shift(-acc_t[i] * ns, LINEAR_FRAC_BITS), 32, f);
                rotate_by(nq, sv, rv);
                for (int i = 0; i < 3; i++)
                    acc_t[i] = clampw(rv[i], 32, f);
                acc_q = nq;
                acc_s = ns;
            end
            default: ;
        endcase
        e.data = {acc_s[31:0], acc_t[2][31:0], acc_t[1][31:0], acc_t[0][31:0],
                  acc_q[3][15:0], acc_q[2][15:0], acc_q[1][15:0], acc_q[0][15:0]};
        e.sat = f;
        expected_accs.push_back(e);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    function automatic logic signed [15:0] rand_q(bit unit);
        int p;
        p = $urandom_range(9);
        if (!unit || p == 0) return 16'($urandom);
        if (p == 1) return ($urandom_range(1) == 1) ? 16'sh7fff : 16'sh8000;
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic signed [31:0] rand_l(bit modest);
        int p;
        p = $urandom_range(11);
        if (!modest || p == 0) return $urandom;
        if (p == 1) return 32'sh7fffffff;
        if (p == 2) return 32'sh80000000;
        if (p == 3) return 0;
        return $signed($urandom_range(32'h00080000)) - 32'sh00040000;
    endfunction

    function automatic xform_req_t mk_req(cmd_t c, logic signed [15:0] w, x, y, z,
                                          logic signed [31:0] a, b, d, s);
        xform_req_t r;
        r = '{c, w, x, y, z, a, b, d, s};
        return r;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                sent++;
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (!hold_sender && pending_reqs.size() > 0) begin
                    xform_req_t r;
                    r = pending_reqs.pop_front();
                    apply_command(r);
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.cmd;
                    s_tdata  <= {r.sc, r.tz, r.ty, r.tx, r.qz, r.qy, r.qx, r.qw};
                    send_gap = gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver backpressure
    int recv_gap = 0;
    always @(posedge aclk) begin
        cycles++;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_accs.size() == 0) begin
                    $display("%0t: unexpected result data=%h sat=%b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    xform_res_t e;
                    e = expected_accs.pop_front();
                    if (m_tuser[0]) sat_seen++;
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[16*i +: 16] !== e.data[16*i +: 16]) begin
                            $display("%0t: rot[%0d] expected %h actual %h", $time, i,
                                     e.data[16*i +: 16], m_tdata[16*i +: 16]);
                            errors++;
                        end
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[64+32*i +: 32] !== e.data[64+32*i +: 32]) begin
                            $display("%0t: linear[%0d] expected %h actual %h", $time, i,
                                     e.data[64+32*i +: 32], m_tdata[64+32*i +: 32]);
                            errors++;
                        end
                    if (m_tuser[0] !== e.sat) begin
                        $display("%0t: saturated expected %b actual %b", $time, e.sat,
                                 m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                recv_gap = 400;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready || !m_tready) begin
                recv_gap = gap_len();
                m_tready <= (recv_gap == 0);
            end
            if (cycles > 3000000) begin
                $display("similarity_transform_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        xform_req_t r;
        aresetn  = 1'b0;
        acc_q = '{QUAT_ONE, 0, 0, 0};
        acc_t = '{0, 0, 0};
        acc_s = LIN_ONE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset state, extremes, zero scale, conjugate of most negative
        pending_reqs.push_back(mk_req(CMD_NONE, 1, 2, 3, 4, 5, 6, 7, 8));
        pending_reqs.push_back(mk_req(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_COMPOSE, 16'sh4000, 0, 0, 0,
                                      32'sh00010000, -32'sh00020000, 32'sh00030000,
                                      32'sh00020000));
        pending_reqs.push_back(mk_req(CMD_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000));
        pending_reqs.push_back(mk_req(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                                      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                      32'sh7fffffff));
        pending_reqs.push_back(mk_req(CMD_COMPOSE, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                      32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                      32'sh7fffffff));
        pending_reqs.push_back(mk_req(CMD_LOAD, 16'sh2d41, 0, 16'sh2d41, 0,
                                      32'sh00050000, 32'sh12345, -32'sh777, 0));
        pending_reqs.push_back(mk_req(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_LOAD, 16'sh4000, 16'sh1000, -16'sh0800, 16'sh0400,
                                      32'sh00011111, -32'sh00022222, 32'sh00033333, 1));
        pending_reqs.push_back(mk_req(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_LOAD, 16'sh4000, 0, 0, 0, 32'sh10000, 0, 0,
                                      -32'sh00008000));
        pending_reqs.push_back(mk_req(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_COMPOSE, 16'sh3000, 16'sh1800, 0, -16'sh1000,
                                      32'sh00100000, 32'sh00200000, -32'sh00300000,
                                      -32'sh00010000));
        pending_reqs.push_back(mk_req(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0));

        // long receiver stall while the sender keeps offering
        wait (pending_reqs.size() == 0);
        long_stall_req = 1'b1;
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(mk_req(cmd_t'($urandom_range(2)), rand_q(1), rand_q(1),
                                          rand_q(1), rand_q(1), rand_l(1), rand_l(1),
                                          rand_l(1), rand_l(1)));
        wait (pending_reqs.size() == 0 && expected_accs.size() == 0);

        // random chains: mostly load then compose/invert runs with plausible values
        while (sent + pending_reqs.size() < 1720) begin
            if (pending_reqs.size() > 8) begin
                @(posedge aclk);
            end else begin
                int p;
                bit modest;
                p = $urandom_range(99);
                modest = ($urandom_range(9) != 0);
                if (p < 3) begin
                    // sender pause until everything has drained
                    wait (pending_reqs.size() == 0 && expected_accs.size() == 0);
                    hold_sender = 1'b1;
                    repeat ($urandom_range(50, 5)) @(posedge aclk);
                    hold_sender = 1'b0;
                end
                if (p < 15)
                    r = mk_req(CMD_LOAD, rand_q(modest), rand_q(modest), rand_q(modest),
                               rand_q(modest), rand_l(modest), rand_l(modest),
                               rand_l(modest), rand_l(modest));
                else
                    r = mk_req(cmd_t'((p < 65) ? CMD_COMPOSE : (p < 97) ? CMD_INVERT
                               : CMD_NONE), rand_q(modest), rand_q(modest),
                               rand_q(modest), rand_q(modest), rand_l(modest),
                               rand_l(modest), rand_l(modest), rand_l(modest));
                pending_reqs.push_back(r);
            end
        end

        wait (pending_reqs.size() == 0 && expected_accs.size() == 0);
        repeat (100) @(posedge aclk);
        $display("ran %0d requests, %0d results checked, %0d with a clamp flagged",
                 sent, results_seen, sat_seen);
        if (errors == 0 && expected_accs.size() == 0)
            $display("similarity_transform_unit verification clean");
        else
            $display("similarity_transform_unit verification failed");
        $finish;
    end
endmodule
